// ===== hw/rtl/pll_pkg.sv =====
// Shared codes, types and fixed port widths for the positional linked list.
package pll_pkg;

  localparam int unsigned ITEM_W    = 32;
  localparam int unsigned REQ_W     = 3;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned FPOS_W    = 6;
  localparam int unsigned COUNT_W   = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND    = 3'd0,
    REQ_INSERT    = 3'd1,
    REQ_RM_FRONT  = 3'd2,
    REQ_RM_AT     = 3'd3,
    REQ_SEARCH    = 3'd4,
    REQ_CLEAR     = 3'd5
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  // Where a new entry lands relative to the current chain.
  typedef enum logic [1:0] {
    MODE_EMPTY = 2'd0,
    MODE_FRONT = 2'd1,
    MODE_END   = 2'd2,
    MODE_MID   = 2'd3
  } mode_e;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ALLOC  = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_FIX    = 7'b0001000,
    S_VICT   = 7'b0010000,
    S_RMHEAD = 7'b0100000,
    S_SEARCH = 7'b1000000
  } state_e;

endpackage

// ===== hw/rtl/positional_linked_list.sv =====
// Bounded singly linked list of signed values held in slot memories.
//
//  channel  | direction | handshake                     | payload
//  ---------+-----------+-------------------------------+-----------------------------------
//  request  | in        | start_i high while busy_o low | req_type_i, item_value_i, position_i
//  result   | out       | result_valid_o, one cycle     | status_o, found_o,
//           |           |                               | found_position_o, entry_count_o
//
// Steps: rejected requests, clear, unknown types and a search of an empty
//   list finish at the accepting edge; append, insert at the front or end and
//   remove front finish in ALLOC or RMHEAD; insert at position p goes through
//   ALLOC, WALK and FIX, remove at position p > 0 through WALK and VICT, and a
//   search visits entries in SEARCH until a match or the last entry. The link
//   memory read port, one link per cycle, sets the walk length. A result shows in the
//   cycle after its request finishes; a new request may be taken in that cycle.
// Reset: head, tail and count go to zero and every slot is free. No memory
//   clearing pass: free-stack entries below the lowest stack depth reached
//   since reset or clear have never been written and read as their own index.
// Stalls: the receiver cannot stall; busy_o holds off new requests.
module positional_linked_list #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic [pll_pkg::REQ_W-1:0]      req_type_i,
  input  logic signed [pll_pkg::ITEM_W-1:0] item_value_i,
  input  logic [pll_pkg::POS_W-1:0]      position_i,
  output logic                           result_valid_o,
  output logic [pll_pkg::STATUS_W-1:0]   status_o,
  output logic                           found_o,
  output logic [pll_pkg::FPOS_W-1:0]     found_position_o,
  output logic [pll_pkg::COUNT_W-1:0]    entry_count_o
);

  localparam int unsigned SLOT_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  // Values are taken from the 32-bit item port, so at most 32 bits are kept.
  localparam int unsigned VB     = (VALUE_BITS < pll_pkg::ITEM_W) ? VALUE_BITS
                                                                 : pll_pkg::ITEM_W;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  // Control state
  pll_pkg::state_e  state_q, state_d;
  pll_pkg::req_e    req_q, req_d;
  pll_pkg::mode_e   mode_q, mode_d;
  logic [SLOT_W-1:0] head_q, head_d;
  logic [SLOT_W-1:0] tail_q, tail_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  free_top_q, free_top_d;
  logic [CNT_W-1:0]  min_top_q, min_top_d;   // lowest stack depth since clear
  logic              res_valid_q, res_valid_d;

  // Working registers (payload, no reset needed)
  logic [VB-1:0]     val_q, val_d;
  logic [SLOT_W-1:0] cur_q, cur_d;           // slot under the walk pointer
  logic [CNT_W-1:0]  k_q, k_d;               // position of cur_q
  logic [CNT_W-1:0]  tgt_q, tgt_d;           // position of the predecessor
  logic [SLOT_W-1:0] slot_q, slot_d;         // new slot or removed slot
  logic              fresh_q, fresh_d;
  pll_pkg::status_e  status_q, status_d;
  logic              found_q, found_d;
  logic [pll_pkg::FPOS_W-1:0] fpos_q, fpos_d;

  // Memory ports
  logic              vl_we;
  logic [SLOT_W-1:0] vl_waddr, vl_raddr;
  logic [VB-1:0]     vl_rdata;
  logic              lk_we;
  logic [SLOT_W-1:0] lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic              fs_we;
  logic [SLOT_W-1:0] fs_waddr, fs_wdata, fs_raddr, fs_rdata;

  pll_ram #(.WIDTH(VB), .DEPTH(CAPACITY)) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (vl_we),
    .waddr_i (vl_waddr),
    .wdata_i (val_q),
    .raddr_i (vl_raddr),
    .rdata_o (vl_rdata)
  );

  pll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  pll_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  // Derived values
  logic [31:0]       pos_ext, cnt_ext, k_ext, tgt_ext, pos_m1;
  logic [CNT_W-1:0]  top_m1;
  logic [SLOT_W-1:0] alloc_slot;
  logic              full, empty;

  assign pos_ext    = 32'(position_i);
  assign cnt_ext    = 32'(count_q);
  assign k_ext      = 32'(k_q);
  assign tgt_ext    = 32'(tgt_q);
  assign pos_m1     = pos_ext - 32'd1;
  assign top_m1     = free_top_q - CNT_W'(1);
  assign full       = (count_q == CAP_CNT);
  assign empty      = (count_q == '0);
  // Top of the free stack: untouched entries hold their own index.
  assign alloc_slot = fresh_q ? top_m1[SLOT_W-1:0] : fs_rdata;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    mode_d      = mode_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    free_top_d  = free_top_q;
    min_top_d   = min_top_q;
    res_valid_d = 1'b0;
    val_d       = val_q;
    cur_d       = cur_q;
    k_d         = k_q;
    tgt_d       = tgt_q;
    slot_d      = slot_q;
    fresh_d     = fresh_q;
    status_d    = status_q;
    found_d     = found_q;
    fpos_d      = fpos_q;

    vl_we    = 1'b0;
    vl_waddr = slot_q;
    vl_raddr = cur_q;
    lk_we    = 1'b0;
    lk_waddr = cur_q;
    lk_wdata = slot_q;
    lk_raddr = cur_q;
    fs_we    = 1'b0;
    fs_waddr = free_top_q[SLOT_W-1:0];
    fs_wdata = slot_q;
    fs_raddr = top_m1[SLOT_W-1:0];

    case (state_q)
      pll_pkg::S_IDLE: begin
        if (start_i) begin
          req_d    = pll_pkg::req_e'(req_type_i);
          val_d    = item_value_i[VB-1:0];
          status_d = pll_pkg::ST_OK;
          found_d  = 1'b0;
          fpos_d   = '0;
          cur_d    = head_q;
          k_d      = '0;
          tgt_d    = pos_m1[CNT_W-1:0];
          fresh_d  = (free_top_q == min_top_q);
          lk_raddr = head_q;
          vl_raddr = head_q;
          case (pll_pkg::req_e'(req_type_i))
            pll_pkg::REQ_APPEND: begin
              if (full) begin
                status_d    = pll_pkg::ST_FULL;
                res_valid_d = 1'b1;
              end else begin
                mode_d  = empty ? pll_pkg::MODE_EMPTY : pll_pkg::MODE_END;
                state_d = pll_pkg::S_ALLOC;
              end
            end
            pll_pkg::REQ_INSERT: begin
              if (pos_ext > cnt_ext) begin
                status_d    = pll_pkg::ST_BAD_POS;
                res_valid_d = 1'b1;
              end else if (full) begin
                status_d    = pll_pkg::ST_FULL;
                res_valid_d = 1'b1;
              end else begin
                if (empty) begin
                  mode_d = pll_pkg::MODE_EMPTY;
                end else if (pos_ext == 32'd0) begin
                  mode_d = pll_pkg::MODE_FRONT;
                end else if (pos_ext == cnt_ext) begin
                  mode_d = pll_pkg::MODE_END;
                end else begin
                  mode_d = pll_pkg::MODE_MID;
                end
                state_d = pll_pkg::S_ALLOC;
              end
            end
            pll_pkg::REQ_RM_FRONT: begin
              if (empty) begin
                status_d    = pll_pkg::ST_EMPTY;
                res_valid_d = 1'b1;
              end else begin
                state_d = pll_pkg::S_RMHEAD;
              end
            end
            pll_pkg::REQ_RM_AT: begin
              if (empty) begin
                status_d    = pll_pkg::ST_EMPTY;
                res_valid_d = 1'b1;
              end else if (pos_ext >= cnt_ext) begin
                status_d    = pll_pkg::ST_BAD_POS;
                res_valid_d = 1'b1;
              end else if (pos_ext == 32'd0) begin
                state_d = pll_pkg::S_RMHEAD;
              end else begin
                state_d = pll_pkg::S_WALK;
              end
            end
            pll_pkg::REQ_SEARCH: begin
              if (empty) begin
                res_valid_d = 1'b1;
              end else begin
                state_d = pll_pkg::S_SEARCH;
              end
            end
            pll_pkg::REQ_CLEAR: begin
              head_d      = '0;
              tail_d      = '0;
              count_d     = '0;
              free_top_d  = CAP_CNT;
              min_top_d   = CAP_CNT;
              res_valid_d = 1'b1;
            end
            default: begin
              res_valid_d = 1'b1;
            end
          endcase
        end
      end

      // Free-stack read is back: pop the slot and store the value.
      pll_pkg::S_ALLOC: begin
        slot_d     = alloc_slot;
        vl_we      = 1'b1;
        vl_waddr   = alloc_slot;
        free_top_d = top_m1;
        min_top_d  = (top_m1 < min_top_q) ? top_m1 : min_top_q;
        case (mode_q)
          pll_pkg::MODE_EMPTY: begin
            head_d      = alloc_slot;
            tail_d      = alloc_slot;
            count_d     = count_q + CNT_W'(1);
            res_valid_d = 1'b1;
            state_d     = pll_pkg::S_IDLE;
          end
          pll_pkg::MODE_FRONT: begin
            lk_we       = 1'b1;
            lk_waddr    = alloc_slot;
            lk_wdata    = head_q;
            head_d      = alloc_slot;
            count_d     = count_q + CNT_W'(1);
            res_valid_d = 1'b1;
            state_d     = pll_pkg::S_IDLE;
          end
          pll_pkg::MODE_END: begin
            lk_we       = 1'b1;
            lk_waddr    = tail_q;
            lk_wdata    = alloc_slot;
            tail_d      = alloc_slot;
            count_d     = count_q + CNT_W'(1);
            res_valid_d = 1'b1;
            state_d     = pll_pkg::S_IDLE;
          end
          default: begin
            cur_d    = head_q;
            k_d      = '0;
            lk_raddr = head_q;
            state_d  = pll_pkg::S_WALK;
          end
        endcase
      end

      // lk_rdata holds link[cur_q]; stop when cur_q is the predecessor.
      pll_pkg::S_WALK: begin
        if (k_q == tgt_q) begin
          if (req_q == pll_pkg::REQ_INSERT) begin
            lk_we    = 1'b1;
            lk_waddr = slot_q;
            lk_wdata = lk_rdata;
            state_d  = pll_pkg::S_FIX;
          end else begin
            slot_d   = lk_rdata;
            lk_raddr = lk_rdata;
            state_d  = pll_pkg::S_VICT;
          end
        end else begin
          cur_d    = lk_rdata;
          k_d      = k_q + CNT_W'(1);
          lk_raddr = lk_rdata;
        end
      end

      pll_pkg::S_FIX: begin
        lk_we       = 1'b1;
        lk_waddr    = cur_q;
        lk_wdata    = slot_q;
        count_d     = count_q + CNT_W'(1);
        res_valid_d = 1'b1;
        state_d     = pll_pkg::S_IDLE;
      end

      // lk_rdata holds the removed entry's link; bypass it.
      pll_pkg::S_VICT: begin
        lk_we       = 1'b1;
        lk_waddr    = cur_q;
        lk_wdata    = lk_rdata;
        if (tgt_ext + 32'd2 == cnt_ext) begin
          tail_d = cur_q;
        end
        fs_we       = 1'b1;
        fs_wdata    = slot_q;
        free_top_d  = free_top_q + CNT_W'(1);
        count_d     = count_q - CNT_W'(1);
        res_valid_d = 1'b1;
        state_d     = pll_pkg::S_IDLE;
      end

      pll_pkg::S_RMHEAD: begin
        fs_we      = 1'b1;
        fs_wdata   = head_q;
        free_top_d = free_top_q + CNT_W'(1);
        count_d    = count_q - CNT_W'(1);
        if (count_q == CNT_W'(1)) begin
          head_d = '0;
          tail_d = '0;
        end else begin
          head_d = lk_rdata;
        end
        res_valid_d = 1'b1;
        state_d     = pll_pkg::S_IDLE;
      end

      // Value and link of cur_q arrive together, one entry per cycle.
      pll_pkg::S_SEARCH: begin
        if (vl_rdata == val_q) begin
          found_d     = 1'b1;
          fpos_d      = k_ext[pll_pkg::FPOS_W-1:0];
          res_valid_d = 1'b1;
          state_d     = pll_pkg::S_IDLE;
        end else if (k_ext + 32'd1 == cnt_ext) begin
          res_valid_d = 1'b1;
          state_d     = pll_pkg::S_IDLE;
        end else begin
          cur_d    = lk_rdata;
          k_d      = k_q + CNT_W'(1);
          lk_raddr = lk_rdata;
          vl_raddr = lk_rdata;
        end
      end

      default: begin
        state_d = pll_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pll_pkg::S_IDLE;
      req_q       <= pll_pkg::REQ_APPEND;
      mode_q      <= pll_pkg::MODE_EMPTY;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      free_top_q  <= CAP_CNT;
      min_top_q   <= CAP_CNT;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      mode_q      <= mode_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      free_top_q  <= free_top_d;
      min_top_q   <= min_top_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    cur_q    <= cur_d;
    k_q      <= k_d;
    tgt_q    <= tgt_d;
    slot_q   <= slot_d;
    fresh_q  <= fresh_d;
    status_q <= status_d;
    found_q  <= found_d;
    fpos_q   <= fpos_d;
  end

  assign busy_o           = (state_q != pll_pkg::S_IDLE);
  assign result_valid_o   = res_valid_q;
  assign status_o         = status_q;
  assign found_o          = found_q;
  assign found_position_o = fpos_q;
  assign entry_count_o    = cnt_ext[pll_pkg::COUNT_W-1:0];

  // A result is only ever shown with the block idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy_o)
    else $error("result strobe while busy");

  // Every accepted request either answers next cycle or keeps the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (result_valid_o || busy_o))
    else $error("accepted request dropped");

  // Slots are conserved between the list and the free stack; a mid insert
  // pops its slot before the count moves, so check only when idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pll_pkg::S_IDLE) |->
      (32'(free_top_q) + 32'(count_q) == 32'(CAPACITY)))
    else $error("slot accounting broken");

  // The untouched-region mark never rises above the stack depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_top_q <= free_top_q)
    else $error("free stack mark above top");

endmodule

// ===== hw/rtl/pll_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module pll_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the positional linked list: scoreboard class, drivers, monitor.
`timescale 1ns / 100ps

module tb;
  import pll_pkg::*;

  localparam int unsigned DEPTH        = 64;
  localparam int unsigned VBITS        = 32;
  localparam int unsigned RANDOM_ITEMS = 1700;
  // Worst request walks DEPTH links plus setup; drain waits that long again.
  localparam int unsigned DRAIN_CYCLES = DEPTH + 8;
  // Hang guard; the limit keeps a big margin over the slowest legal run.
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  // Request codes the block does not define; it must answer them as no-ops.
  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;

  typedef struct packed {
    status_e             status;
    logic                found;
    logic [FPOS_W-1:0]   fpos;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  // Shadow list plus queue of results still owed by the block.
  class list_scoreboard;
    logic [ITEM_W-1:0] entries[$];
    outcome_t          owed[$];
    int unsigned       mismatches    = 0;
    int unsigned       requests      = 0;
    int unsigned       hits          = 0;
    int unsigned       full_rejects  = 0;
    int unsigned       pos_rejects   = 0;
    int unsigned       empty_rejects = 0;
    int unsigned       peak          = 0;

    // Position check ahead of the capacity check; p == size is an append.
    function status_e place(logic [ITEM_W-1:0] v, int unsigned p);
      if (p > entries.size()) return ST_BAD_POS;
      if (entries.size() >= DEPTH) return ST_FULL;
      entries.insert(p, v);
      return ST_OK;
    endfunction

    function status_e unlink(int unsigned p);
      if (entries.size() == 0) return ST_EMPTY;
      if (p >= entries.size()) return ST_BAD_POS;
      entries.delete(p);
      return ST_OK;
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic [ITEM_W-1:0] v,
                               logic [POS_W-1:0] pos);
      outcome_t o;
      o = '0;
      o.status = ST_OK;
      case (req)
        REQ_APPEND:   o.status = place(v, entries.size());
        REQ_INSERT:   o.status = place(v, pos);
        REQ_RM_FRONT: o.status = unlink(0);
        REQ_RM_AT:    o.status = unlink(pos);
        REQ_SEARCH: begin
          // first match wins
          foreach (entries[i]) begin
            if (!o.found && entries[i] == v) begin
              o.found = 1'b1;
              o.fpos  = FPOS_W'(i);
            end
          end
        end
        REQ_CLEAR:    entries.delete();
        default:      ;
      endcase
      o.count = COUNT_W'(entries.size());
      requests++;
      if (o.found) hits++;
      if (o.status == ST_FULL) full_rejects++;
      if (o.status == ST_BAD_POS) pos_rejects++;
      if (o.status == ST_EMPTY) empty_rejects++;
      if (entries.size() > peak) peak = entries.size();
      owed.push_back(o);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic fnd,
                               logic [FPOS_W-1:0] fp, logic [COUNT_W-1:0] cnt);
      outcome_t o;
      if (owed.size() == 0) begin
        $error("result with no request outstanding: status %0d count %0d", st, cnt);
        mismatches++;
        return;
      end
      o = owed.pop_front();
      if (st !== o.status) begin
        $error("status: expected %0d, got %0d", o.status, st);
        mismatches++;
      end
      if (fnd !== o.found) begin
        $error("found: expected %0d, got %0d", o.found, fnd);
        mismatches++;
      end
      if (fp !== o.fpos) begin
        $error("found_position: expected %0d, got %0d", o.fpos, fp);
        mismatches++;
      end
      if (cnt !== o.count) begin
        $error("entry_count: expected %0d, got %0d", o.count, cnt);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      start_i;
  logic                      busy_o;
  logic [REQ_W-1:0]          req_type_i;
  logic signed [ITEM_W-1:0]  item_value_i;
  logic [POS_W-1:0]          position_i;
  logic                      result_valid_o;
  logic [STATUS_W-1:0]       status_o;
  logic                      found_o;
  logic [FPOS_W-1:0]         found_position_o;
  logic [COUNT_W-1:0]        entry_count_o;

  list_scoreboard sb = new();
  int unsigned    idle_pct = 0;   // chance per cycle that the sender holds back
  int unsigned    cycles   = 0;

  positional_linked_list #(
    .CAPACITY   (DEPTH),
    .VALUE_BITS (VBITS)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .item_value_i     (item_value_i),
    .position_i       (position_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .found_o          (found_o),
    .found_position_o (found_position_o),
    .entry_count_o    (entry_count_o)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or drops a result.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycles, sb.pending());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result strobe lasts one cycle; sample it at the edge that closes it.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      sb.check_result(status_o, found_o, found_position_o, entry_count_o);
  end

  // Random position: mostly legal (0..top), then the first illegal one, then anything.
  function automatic logic [POS_W-1:0] pick_pos(int unsigned top);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return POS_W'($urandom_range(top));
    if (r < 92) return POS_W'(top + 1);
    return POS_W'($urandom_range(127));
  endfunction

  // Drive one request and hold it until the block takes it. Called right after
  // a rising edge, so start_i gets at most one assignment per time step.
  task automatic issue(input logic [REQ_W-1:0] req, input logic [ITEM_W-1:0] v,
                       input logic [POS_W-1:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i      <= 1'b1;
    req_type_i   <= req;
    item_value_i <= v;
    position_i   <= pos;
    // busy_o read here is the value before this edge's updates
    do @(posedge clk_i); while (busy_o);
    sb.note_request(req, v, pos);
  endtask

  initial begin
    int unsigned       phase_idle[3];
    int unsigned       n;
    int unsigned       r;
    int unsigned       grow;
    int unsigned       epoch_left;
    logic [REQ_W-1:0]  req;
    logic [ITEM_W-1:0] v;
    logic [POS_W-1:0]  pos;

    phase_idle = '{9, 80, 0};
    start_i      <= 1'b0;
    req_type_i   <= '0;
    item_value_i <= '0;
    position_i   <= '0;
    rst_ni       <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // empty-list corners
    issue(REQ_SEARCH,   32'd5,            7'd0);
    issue(REQ_RM_FRONT, 32'd0,            7'd0);
    issue(REQ_RM_AT,    32'd0,            7'd0);
    issue(REQ_INSERT,   32'd9,            7'd1);   // position above count
    issue(REQ_INSERT,   32'h7FFF_FFFF,    7'd0);   // first entry via insert
    issue(REQ_APPEND,   32'h8000_0000,    7'd0);
    issue(REQ_INSERT,   32'hFFFF_FFFF,    7'd2);   // position == count: append
    issue(REQ_INSERT,   32'd0,            7'd1);   // middle, walks the chain
    issue(REQ_INSERT,   32'h5555_5555,    7'd0);   // new head
    issue(REQ_APPEND,   32'hAAAA_AAAA,    7'd127);
    issue(REQ_APPEND,   32'h7FFF_FFFF,    7'd0);   // duplicate of entry 1
    issue(REQ_SEARCH,   32'hFFFF_FFFF,    7'd0);
    issue(REQ_SEARCH,   32'd12345,        7'd0);   // miss
    issue(REQ_SEARCH,   32'h7FFF_FFFF,    7'd0);   // must report first copy
    n = sb.entries.size();
    issue(REQ_RM_AT,    32'd0,            POS_W'(n));      // position == count
    issue(REQ_RM_AT,    32'd0,            7'd127);
    issue(REQ_INSERT,   32'd3,            7'd127);
    issue(REQ_RM_AT,    32'd0,            POS_W'(n - 1));  // last entry: tail moves back
    issue(REQ_APPEND,   32'd7,            7'd0);           // lands after new tail
    issue(REQ_SEARCH,   32'd7,            7'd0);
    issue(REQ_SPARE_LO, 32'd1,            7'd5);
    issue(REQ_SPARE_HI, 32'hFFFF_FFFF,    7'd127);
    issue(REQ_CLEAR,    32'd0,            7'd0);
    issue(REQ_APPEND,   32'd1,            7'd0);
    issue(REQ_RM_FRONT, 32'd0,            7'd0);           // list goes empty
    issue(REQ_APPEND,   32'd2,            7'd0);

    // ---- random part ----
    // Alternate growth and shrink epochs so the list fills up (full rejects)
    // and drains to empty many times; clear shows up only while shrinking.
    grow       = 85;
    epoch_left = $urandom_range(200, 120);
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = phase_idle[ph];
      for (int k = 0; k < RANDOM_ITEMS / 3; k++) begin
        if (epoch_left == 0) begin
          grow       = (grow > 50) ? 25 : 85;
          epoch_left = $urandom_range(200, 60);
        end
        epoch_left--;
        n = sb.entries.size();

        // value: small pool for duplicates, extremes, or any 32-bit word
        r = $urandom_range(99);
        if (r < 40) v = ITEM_W'(int'($urandom_range(15)) - 8);
        else if (r < 50) begin
          case ($urandom_range(3))
            0:       v = 32'h7FFF_FFFF;
            1:       v = 32'h8000_0000;
            2:       v = '0;
            default: v = '1;
          endcase
        end else v = $urandom();
        pos = POS_W'($urandom_range(127));

        r = $urandom_range(999);
        if (r < 10 && grow < 50) req = REQ_CLEAR;
        else if (r < 30) req = $urandom_range(1) ? REQ_SPARE_HI : REQ_SPARE_LO;
        else if (r < 180) begin
          req = REQ_SEARCH;
          // mostly look for something that is there, at any depth
          if (n > 0 && $urandom_range(99) < 60) v = sb.entries[$urandom_range(n - 1)];
        end else if ($urandom_range(99) < grow) begin
          if ($urandom_range(1)) req = REQ_APPEND;
          else begin
            req = REQ_INSERT;
            pos = pick_pos(n);
          end
        end else begin
          if ($urandom_range(2) == 0) req = REQ_RM_FRONT;
          else begin
            req = REQ_RM_AT;
            pos = pick_pos((n > 0) ? n - 1 : 0);
          end
        end
        issue(req, v, pos);
      end
      // Once: hold the sender off until every owed result is back.
      if (ph == 0) begin
        start_i <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
    end

    // ---- wind down ----
    start_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests in %0d cycles: %0d search hits, peak of %0d entries",
             sb.requests, cycles, sb.hits, sb.peak);
    $display("rejects: %0d full, %0d bad position, %0d empty; idle 9%%, 80%%, 0%% phases",
             sb.full_rejects, sb.pos_rejects, sb.empty_rejects);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
